/* src/kernel_duration_profile_store_top_macros.svh */
// Assertion macros for the kernel duration profile store.
// Included by the RTL files that carry concurrent assertions.
`ifndef KERNEL_DURATION_PROFILE_STORE_TOP_MACROS_SVH
`define KERNEL_DURATION_PROFILE_STORE_TOP_MACROS_SVH
`ifndef SYNTH
`define KDPS_ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("kdps assertion failed");
`define KDPS_ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("kdps assertion failed");
`else
`define KDPS_ASSERT_RST(lbl, clk, rstn, prop)
`define KDPS_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

/* src/kdps_pkg.sv */
// Package for the kernel duration profile store: sizes, codes and types.
// No dependencies.
package kdps_pkg;

  localparam int TABLE_ENTRIES  = 256;
  localparam int DURATION_BITS  = 48;
  localparam int IDX_BITS       = $clog2(TABLE_ENTRIES);
  localparam int FILL_BITS      = $clog2(TABLE_ENTRIES + 1);
  localparam int GRID_KEY_BITS  = 63;
  localparam int BLOCK_KEY_BITS = 29;
  localparam int THRESH_BITS    = 48;
  localparam int GX_BITS        = 31;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 48;
  localparam int CMP_BITS       = (DURATION_BITS > THRESH_BITS) ? DURATION_BITS : THRESH_BITS;

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(5000000);
  localparam logic [GX_BITS-1:0]     MAX_GX_RESET = GX_BITS'(256);

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLOSENESS   = 2'd0,
    CFG_MAX_MODE_GX = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } scan_state_e;

  typedef struct packed {
    logic [THRESH_BITS-1:0] threshold;
    logic [GX_BITS-1:0]     max_gx;
  } cfg_t;

  typedef struct packed {
    action_e                  action;
    logic [GRID_KEY_BITS-1:0] gkey;
    logic [BLOCK_KEY_BITS-1:0] bkey;
    logic [DURATION_BITS-1:0] dur;
  } item_t;

  typedef struct packed {
    logic [GRID_KEY_BITS-1:0]  gkey;
    logic [BLOCK_KEY_BITS-1:0] bkey;
    logic [DURATION_BITS-1:0]  dur;
  } entry_t;

  typedef struct packed {
    logic                     found;
    logic [DURATION_BITS-1:0] duration;
    logic                     stored;
    logic                     full;
  } result_t;

endpackage

/* src/kernel_duration_profile_store_top.sv */
// Top level of the kernel duration profile store: ports, configuration
// registers and result register. Depends on kdps_pkg and kdps_scan.
//
//  channel  direction  handshake                 payload
//  in       sink       in_valid_i / in_stall_o   action_i, grid_*_i, block_*_i, sample_duration_i
//  out      source     out_valid_o / out_stall_i found_o, duration_out_o, stored_o, table_full_o
//  cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// The scan of an item makes one table memory read per stored entry, and
// in_stall_o holds off the next item until its result has been passed to
// the output register.
// Reset empties the table at once through the fill count; no clearing pass.
// A stalled result sits in the output register; the scan of the next item
// runs meanwhile and waits at its end until the register frees.
module kernel_duration_profile_store_top
  import kdps_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      action_i,
  input  logic [30:0]               grid_x_i,
  input  logic [15:0]               grid_y_i,
  input  logic [15:0]               grid_z_i,
  input  logic [10:0]               block_x_i,
  input  logic [10:0]               block_y_i,
  input  logic [6:0]                block_z_i,
  input  logic [DURATION_BITS-1:0]  sample_duration_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      found_o,
  output logic [DURATION_BITS-1:0]  duration_out_o,
  output logic                      stored_o,
  output logic                      table_full_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  item_t   item;
  logic    busy;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_valid_q;
  result_t out_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CLOSENESS:   cfg_d.threshold = cfg_data_i[THRESH_BITS-1:0];
        CFG_MAX_MODE_GX: cfg_d.max_gx    = cfg_data_i[GX_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESH_RESET;
      cfg_q.max_gx    <= MAX_GX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign item.action = action_e'(action_i);
  assign item.gkey   = {grid_x_i, grid_y_i, grid_z_i};
  assign item.bkey   = {block_x_i, block_y_i, block_z_i};
  assign item.dur    = sample_duration_i;

  kdps_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_valid_i(in_valid_i),
    .item_i      (item),
    .item_busy_o (busy),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign in_stall_o = busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_q.found;
  assign duration_out_o = out_q.duration;
  assign stored_o       = out_q.stored;
  assign table_full_o   = out_q.full;

endmodule

/* src/kdps_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module kdps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/kdps_scan.sv */
// Scan engine: walks the filled table entries, matches signatures, appends.
// Depends on kdps_pkg, kdps_ram and the assertion macro header.
`include "kernel_duration_profile_store_top_macros.svh"

module kdps_scan
  import kdps_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_busy_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_ready_i
);

  scan_state_e state_q, state_d;
  logic [FILL_BITS-1:0] fill_q, fill_d;
  logic [FILL_BITS-1:0] count_q, count_d;
  logic [FILL_BITS-1:0] rd_idx_q, rd_idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic                 hit_q, hit_d;
  logic                 close_q, close_d;
  logic                 max_mode_q, max_mode_d;
  logic [DURATION_BITS-1:0] best_q, best_d;
  item_t  item_q, item_d;

  logic   rd_en;
  logic   we;
  entry_t rdata;
  entry_t wdata;
  logic   key_hit;
  logic [DURATION_BITS-1:0] diff;
  logic   want_new;
  logic   room;

  assign rd_en = (state_q == ST_SCAN) && (rd_idx_q < count_q);
  assign wdata = '{gkey: item_q.gkey, bkey: item_q.bkey, dur: item_q.dur};

  kdps_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(fill_q[IDX_BITS-1:0]),
    .wdata_i(wdata),
    .raddr_i(rd_idx_q[IDX_BITS-1:0]),
    .rdata_o(rdata)
  );

  assign key_hit  = (rdata.gkey == item_q.gkey) && (rdata.bkey == item_q.bkey);
  assign diff     = (rdata.dur > item_q.dur) ? (rdata.dur - item_q.dur)
                                              : (item_q.dur - rdata.dur);
  assign want_new = !close_q;
  assign room     = fill_q < FILL_BITS'(TABLE_ENTRIES);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    count_d     = count_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    hit_d       = hit_q;
    close_d     = close_q;
    max_mode_d  = max_mode_q;
    best_d      = best_q;
    item_d      = item_q;
    we          = 1'b0;
    item_busy_o = (state_q != ST_IDLE);
    res_valid_o = 1'b0;
    res_o       = '0;

    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_d     = item_i;
          max_mode_d = (item_i.gkey[GRID_KEY_BITS-1 -: GX_BITS] == cfg_i.max_gx);
          count_d    = fill_q;
          rd_idx_d   = '0;
          hit_d      = 1'b0;
          close_d    = 1'b0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_idx_d = rd_idx_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q && key_hit) begin
          if (CMP_BITS'(diff) < CMP_BITS'(cfg_i.threshold)) begin
            close_d = 1'b1;
          end
          if (!hit_q) begin
            best_d = rdata.dur;
            hit_d  = 1'b1;
          end else if (max_mode_q ? (rdata.dur > best_q) : (rdata.dur < best_q)) begin
            best_d = rdata.dur;
          end
        end
        if (!rd_en && !rd_vld_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
        if (item_q.action == ACT_LOOKUP) begin
          res_o.found    = hit_q;
          res_o.duration = hit_q ? best_q : '0;
        end else begin
          res_o.stored = want_new && room;
          res_o.full   = want_new && !room;
        end
        if (res_ready_i) begin
          we      = res_o.stored;
          state_d = ST_IDLE;
          if (res_o.stored) begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q    <= count_d;
    rd_idx_q   <= rd_idx_d;
    hit_q      <= hit_d;
    close_q    <= close_d;
    max_mode_q <= max_mode_d;
    best_q     <= best_d;
    item_q     <= item_d;
  end

  `KDPS_ASSERT_CLK(a_fill_bound, clk_i, fill_q <= FILL_BITS'(TABLE_ENTRIES))
  `KDPS_ASSERT_RST(a_store_grows, clk_i, rst_ni,
    (res_valid_o && res_ready_i && res_o.stored) |=> (fill_q == $past(fill_q) + 1'b1))
  `KDPS_ASSERT_RST(a_full_means_full, clk_i, rst_ni,
    (res_valid_o && res_o.full) |-> (fill_q == FILL_BITS'(TABLE_ENTRIES)))
  `KDPS_ASSERT_RST(a_result_kind, clk_i, rst_ni,
    (res_valid_o && (res_o.found || res_o.duration != '0)) |-> (item_q.action == ACT_LOOKUP))
  `KDPS_ASSERT_RST(a_no_read_in_done, clk_i, rst_ni,
    (state_q == ST_DONE) |-> (!rd_vld_q && !(rd_idx_q < count_q)))

endmodule

/* bench/kernel_duration_profile_store_top_tb.sv */
// Self-checking bench for kernel_duration_profile_store_top: drives launch records with
// random gaps and output stalls, predicts each result from its own profile table.
// Depends on kdps_pkg and the kernel_duration_profile_store_top RTL.
module kernel_duration_profile_store_top_tb;
  import kdps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;
  localparam int POOL_SIZE = 16;

  typedef struct {
    action_e                  act;
    logic [GX_BITS-1:0]       gx;
    logic [15:0]              gy;
    logic [15:0]              gz;
    logic [10:0]              bx;
    logic [10:0]              by;
    logic [6:0]               bz;
    logic [DURATION_BITS-1:0] dur;
  } launch_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     action_i;
  logic [30:0]              grid_x_i;
  logic [15:0]              grid_y_i;
  logic [15:0]              grid_z_i;
  logic [10:0]              block_x_i;
  logic [10:0]              block_y_i;
  logic [6:0]               block_z_i;
  logic [DURATION_BITS-1:0] sample_duration_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     found_o;
  logic [DURATION_BITS-1:0] duration_out_o;
  logic                     stored_o;
  logic                     table_full_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  // profile table mirror
  logic [GRID_KEY_BITS-1:0]  slot_gkey [TABLE_ENTRIES];
  logic [BLOCK_KEY_BITS-1:0] slot_bkey [TABLE_ENTRIES];
  logic [DURATION_BITS-1:0]  slot_dur  [TABLE_ENTRIES];
  int                        slots_filled = 0;
  logic [THRESH_BITS-1:0]    near_limit = THRESH_RESET;
  logic [GX_BITS-1:0]        longest_gx = MAX_GX_RESET;

  result_t pending_results[$];
  int      mismatch_count = 0;
  bit      calm = 1'b0;
  launch_t sig_pool [POOL_SIZE];

  kernel_duration_profile_store_top u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic result_t profile_predict(input launch_t it);
    result_t                   r;
    logic [GRID_KEY_BITS-1:0]  gk;
    logic [BLOCK_KEY_BITS-1:0] bk;
    logic [DURATION_BITS-1:0]  d;
    logic [DURATION_BITS-1:0]  spread;
    bit                        near;
    r = '0;
    near = 1'b0;
    gk = {it.gx, it.gy, it.gz};
    bk = {it.bx, it.by, it.bz};
    for (int i = 0; i < slots_filled; i++) begin
      if (slot_gkey[i] == gk && slot_bkey[i] == bk) begin
        d = slot_dur[i];
        if (it.act == ACT_INSERT) begin
          spread = (d > it.dur) ? d - it.dur : it.dur - d;
          if (THRESH_BITS'(spread) < near_limit) near = 1'b1;
        end else if (!r.found) begin
          r.found = 1'b1;
          r.duration = d;
        end else if ((it.gx == longest_gx) ? (d > r.duration) : (d < r.duration)) begin
          r.duration = d;
        end
      end
    end
    if (it.act == ACT_INSERT && !near) begin
      if (slots_filled < TABLE_ENTRIES) begin
        slot_gkey[slots_filled] = gk;
        slot_bkey[slots_filled] = bk;
        slot_dur[slots_filled] = it.dur;
        slots_filled++;
        r.stored = 1'b1;
      end else begin
        r.full = 1'b1;
      end
    end
    return r;
  endfunction

  // result check
  initial begin
    int unsigned hold;
    result_t     want;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 16);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing pending");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          mismatch_count++;
        end
        if (duration_out_o !== want.duration) begin
          $error("duration_out: expected %0d, got %0d", want.duration, duration_out_o);
          mismatch_count++;
        end
        if (stored_o !== want.stored) begin
          $error("stored: expected %0d, got %0d", want.stored, stored_o);
          mismatch_count++;
        end
        if (table_full_o !== want.full) begin
          $error("table_full: expected %0d, got %0d", want.full, table_full_o);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_launch(input launch_t it);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    action_i <= it.act;
    grid_x_i <= it.gx;
    grid_y_i <= it.gy;
    grid_z_i <= it.gz;
    block_x_i <= it.bx;
    block_y_i <= it.by;
    block_z_i <= it.bz;
    sample_duration_i <= it.dur;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(profile_predict(it));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // spare indexes get junk that must not land anywhere
  task automatic program_regs(input logic [THRESH_BITS-1:0] thr,
                              input logic [GX_BITS-1:0] gx);
    logic [CFG_DATA_BITS-1:0] junk;
    junk = CFG_DATA_BITS'({$urandom, $urandom});
    cfg_write(CFG_CLOSENESS, CFG_DATA_BITS'(thr));
    cfg_write(CFG_MAX_MODE_GX, {junk[CFG_DATA_BITS-1:GX_BITS], gx});
    cfg_write(CFG_SPARE_A, junk);
    cfg_write(CFG_SPARE_B, ~junk);
    cfg_valid_i <= 1'b0;
    near_limit = thr;
    longest_gx = gx;
  endtask

  function automatic launch_t make_launch(input action_e act, input logic [GX_BITS-1:0] gx,
                                          input logic [15:0] gy, input logic [15:0] gz,
                                          input logic [10:0] bx, input logic [10:0] by,
                                          input logic [6:0] bz,
                                          input logic [DURATION_BITS-1:0] dur);
    launch_t s;
    s.act = act;
    s.gx = gx;
    s.gy = gy;
    s.gz = gz;
    s.bx = bx;
    s.by = by;
    s.bz = bz;
    s.dur = dur;
    return s;
  endfunction

  function automatic launch_t random_sig();
    launch_t s;
    case ($urandom_range(0, 2))
      0: s.gx = GX_BITS'($urandom);
      1: s.gx = GX_BITS'($urandom_range(1, 4096));
      default: s.gx = longest_gx;
    endcase
    s.gy = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 8));
    s.gz = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 8));
    s.bx = 11'($urandom_range(0, 1024));
    s.by = 11'($urandom_range(0, 1024));
    s.bz = 7'($urandom_range(0, 64));
    s.act = ACT_INSERT;
    s.dur = '0;
    return s;
  endfunction

  // biased toward values right at the closeness edge of stored samples
  function automatic logic [DURATION_BITS-1:0] pick_duration(input launch_t s);
    logic [DURATION_BITS-1:0] seen[$];
    logic [DURATION_BITS-1:0] base;
    logic [DURATION_BITS-1:0] off;
    for (int i = 0; i < slots_filled; i++) begin
      if (slot_gkey[i] == {s.gx, s.gy, s.gz} && slot_bkey[i] == {s.bx, s.by, s.bz})
        seen.push_back(slot_dur[i]);
    end
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return DURATION_BITS'({$urandom, $urandom});
      4: return DURATION_BITS'($urandom_range(0, 30_000_000));
      default: begin
        if (seen.size() == 0) return DURATION_BITS'($urandom_range(0, 30_000_000));
        base = seen[$urandom_range(0, seen.size() - 1)];
        off = DURATION_BITS'(near_limit) + DURATION_BITS'($urandom_range(0, 2)) - 1'b1;
        return $urandom_range(0, 1) ? base + off : base - off;
      end
    endcase
  endfunction

  task automatic run_mix(input int count, input int fresh_pct);
    launch_t it;
    repeat (count) begin
      if ($urandom_range(1, 100) <= fresh_pct) it = random_sig();
      else it = sig_pool[$urandom_range(0, POOL_SIZE - 1)];
      it.act = $urandom_range(0, 1) ? ACT_LOOKUP : ACT_INSERT;
      it.dur = pick_duration(it);
      send_launch(it);
    end
  endtask

  task automatic test_empty_lookup();
    send_launch(make_launch(ACT_LOOKUP, 31'd7, 16'd1, 16'd1, 11'd32, 11'd1, 7'd1, 48'd99));
  endtask

  task automatic test_insert_duplicate();
    send_launch(make_launch(ACT_INSERT, 31'd7, 16'd1, 16'd1, 11'd32, 11'd1, 7'd1, 48'd1000));
    send_launch(make_launch(ACT_INSERT, 31'd7, 16'd1, 16'd1, 11'd32, 11'd1, 7'd1,
                            48'd5_000_999));
    send_launch(make_launch(ACT_INSERT, 31'd7, 16'd1, 16'd1, 11'd32, 11'd1, 7'd1,
                            48'd5_001_000));
    send_launch(make_launch(ACT_LOOKUP, 31'd7, 16'd1, 16'd1, 11'd32, 11'd1, 7'd1, '1));
  endtask

  task automatic test_longest_mode();
    send_launch(make_launch(ACT_INSERT, 31'd256, 16'd2, 16'd3, 11'd64, 11'd4, 7'd2, '0));
    send_launch(make_launch(ACT_INSERT, 31'd256, 16'd2, 16'd3, 11'd64, 11'd4, 7'd2, '0));
    send_launch(make_launch(ACT_LOOKUP, 31'd256, 16'd2, 16'd3, 11'd64, 11'd4, 7'd2, '0));
    send_launch(make_launch(ACT_INSERT, 31'd256, 16'd2, 16'd3, 11'd64, 11'd4, 7'd2, '1));
    send_launch(make_launch(ACT_LOOKUP, 31'd256, 16'd2, 16'd3, 11'd64, 11'd4, 7'd2, '0));
    send_launch(make_launch(ACT_LOOKUP, 31'd256, 16'd9, 16'd3, 11'd64, 11'd4, 7'd2, '0));
  endtask

  task automatic test_field_extremes();
    send_launch(make_launch(ACT_INSERT, '1, '1, '1, 11'd1024, 11'd1024, 7'd64, '1));
    send_launch(make_launch(ACT_LOOKUP, '1, '1, '1, 11'd1024, 11'd1024, 7'd64, '0));
    send_launch(make_launch(ACT_LOOKUP, '1, '1, '1, 11'd1024, 11'd1024, 7'd63, '0));
    send_launch(make_launch(ACT_INSERT, '0, '0, '0, '0, '0, '0, '0));
    send_launch(make_launch(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '1));
  endtask

  task automatic test_register_extremes();
    settle();
    program_regs('0, '0);
    send_launch(make_launch(ACT_INSERT, 31'd7, 16'd1, 16'd1, 11'd32, 11'd1, 7'd1, 48'd1000));
    send_launch(make_launch(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0));
    settle();
    program_regs('1, '1);
    send_launch(make_launch(ACT_INSERT, '1, '1, '1, 11'd1024, 11'd1024, 7'd64, '0));
    send_launch(make_launch(ACT_INSERT, '1, '1, '1, 11'd1024, 11'd1024, 7'd64, 48'd1));
    send_launch(make_launch(ACT_LOOKUP, '1, '1, '1, 11'd1024, 11'd1024, 7'd64, '0));
    settle();
    program_regs(THRESH_RESET, MAX_GX_RESET);
  endtask

  task automatic test_growing_table();
    foreach (sig_pool[i]) sig_pool[i] = random_sig();
    run_mix(150, 10);
  endtask

  task automatic test_table_full();
    launch_t it;
    settle();
    program_regs('0, sig_pool[1].gx);
    while (slots_filled < TABLE_ENTRIES) begin
      it = sig_pool[$urandom_range(0, POOL_SIZE - 1)];
      it.act = ACT_INSERT;
      it.dur = DURATION_BITS'({$urandom, $urandom});
      send_launch(it);
    end
    repeat (6) begin
      it = random_sig();
      it.dur = pick_duration(it);
      send_launch(it);
    end
    repeat (4) begin
      it = sig_pool[$urandom_range(0, POOL_SIZE - 1)];
      it.act = ACT_LOOKUP;
      send_launch(it);
    end
  endtask

  task automatic test_full_table_mix();
    settle();
    calm = 1'b1;
    program_regs(THRESH_RESET, sig_pool[0].gx);
    run_mix(120, 10);
    settle();
    calm = 1'b0;
    program_regs(THRESH_BITS'({$urandom, $urandom}), sig_pool[3].gx);
    run_mix(120, 10);
    settle();
    program_regs(THRESH_BITS'(1), '0);
    run_mix(120, 10);
    settle();
    program_regs('1, sig_pool[7].gx);
    run_mix(120, 10);
    settle();
    program_regs('0, GX_BITS'($urandom));
    run_mix(120, 10);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    grid_x_i = '0;
    grid_y_i = '0;
    grid_z_i = '0;
    block_x_i = '0;
    block_y_i = '0;
    block_z_i = '0;
    sample_duration_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_lookup();
    test_insert_duplicate();
    test_longest_mode();
    test_field_extremes();
    test_register_extremes();
    test_growing_table();
    test_table_full();
    test_full_table_mix();

    settle();
    repeat (TABLE_ENTRIES + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
